### src/lrn_pkg.sv
// Shared constants, types and helpers of the linear recurrence term engine.
`default_nettype none
package lrn_pkg;

    localparam int MAX_ORDER = 16;
    localparam int DW        = 27;
    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 5;
    localparam int IDXW      = 63;
    localparam int ORDER_W   = 5;

    localparam logic [DW-1:0] MODULUS = DW'(104857601);

    // Barrett reduction constants for 2^26 <= M < 2^27
    localparam int QW = DW + 1;
    localparam int RW = DW + 2;
    localparam logic [QW-1:0] MU = QW'((64'd1 << (2 * DW)) / 64'(MODULUS));

    localparam int KW = $clog2(MAX_ORDER + 1);
    localparam int OW = $clog2(2 * MAX_ORDER + 2);
    localparam int XW = (KW > SLOT_W) ? KW : SLOT_W;
    localparam int YW = (KW > ORDER_W) ? KW : ORDER_W;

    // Work memory map
    localparam int TERM_BASE = 0;
    localparam int COEF_BASE = TERM_BASE + 2 * MAX_ORDER;
    localparam int PROD_BASE = COEF_BASE + MAX_ORDER + 1;
    localparam int INIT_BASE = PROD_BASE + MAX_ORDER + 1;
    localparam int DEN_BASE  = INIT_BASE + MAX_ORDER;
    localparam int RAM_DEPTH = DEN_BASE + MAX_ORDER + 1;
    localparam int AW        = $clog2(RAM_DEPTH);

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD_TERM = 2'd0,
        FN_LOAD_COEF = 2'd1,
        FN_QUERY     = 2'd2
    } t_func;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_COPY  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_MAC   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic vld;
        logic neg;
    } t_mac_tag;

    typedef struct packed {
        logic vld;
        logic neg;
        logic busy;
    } t_mac_res;

    function automatic logic [DW-1:0] neg_mod(input logic [DW-1:0] x);
        logic [DW-1:0] r;
        r = (x == '0) ? '0 : MODULUS - x;
        return r;
    endfunction

endpackage
`default_nettype wire

### src/lrn_if.sv
// Request and response channel interfaces of the term engine.
`default_nettype none
interface lrn_req_if import lrn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    logic [DW-1:0]     value;
    logic [IDXW-1:0]   term_number;

    modport source (output valid, func, slot, value, term_number, input ready);
    modport sink   (input valid, func, slot, value, term_number, output ready);
endinterface

interface lrn_rsp_if import lrn_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [DW-1:0] term;

    modport source (output valid, term, input ready);
    modport sink   (input valid, term, output ready);
endinterface
`default_nettype wire

### src/lrn_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module lrn_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr_a,
    input  wire logic [$clog2(D)-1:0] i_raddr_b,
    output logic      [W-1:0]         o_rdata_a,
    output logic      [W-1:0]         o_rdata_b
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

### src/lrn_mulmod.sv
// Pipelined modular multiplier: product, then Barrett reduction in three stages.
`default_nettype none
module lrn_mulmod import lrn_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_mac_tag      i_tag,
    input  wire logic [DW-1:0] i_a,
    input  wire logic [DW-1:0] i_b,
    output t_mac_res           o_res,
    output logic      [DW-1:0] o_r
);
    logic [3:0] r_v;
    logic [3:0] r_n;
    logic [2*DW-1:0] r_p;
    logic [2*DW-1:0] r_x2;
    logic [QW-1:0]   r_qe;
    logic [RW-1:0]   r_x3;
    logic [RW-1:0]   r_qm;
    logic [DW-1:0]   r_r;

    logic [2*DW-1:0]  w_p;
    logic [2*QW-1:0]  w_qmu;
    logic [QW+DW-1:0] w_qm;
    logic [RW-1:0]    w_r;
    logic [RW-1:0]    w_m1;
    logic [RW-1:0]    w_m2;

    assign w_p   = (2*DW)'(i_a) * (2*DW)'(i_b);
    assign w_qmu = (2*QW)'(r_p[2*DW-1:DW-1]) * (2*QW)'(MU);
    assign w_qm  = (QW+DW)'(r_qe) * (QW+DW)'(MODULUS);
    assign w_r   = r_x3 - r_qm;
    assign w_m1  = RW'(MODULUS);
    assign w_m2  = RW'(MODULUS) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_tag.vld};
        end
        r_n  <= {r_n[2:0], i_tag.neg};
        r_p  <= w_p;
        r_x2 <= r_p;
        r_qe <= w_qmu[2*QW-1:QW];
        r_x3 <= r_x2[RW-1:0];
        r_qm <= w_qm[RW-1:0];
        // remainder lies below 3M: fold at most twice
        if (w_r >= w_m2) begin
            r_r <= DW'(w_r - w_m2);
        end else if (w_r >= w_m1) begin
            r_r <= DW'(w_r - w_m1);
        end else begin
            r_r <= DW'(w_r);
        end
    end

    assign o_res.vld  = r_v[3];
    assign o_res.neg  = r_n[3];
    assign o_res.busy = |r_v;
    assign o_r        = r_r;
endmodule
`default_nettype wire

### src/linear_recurrence_nth_term.sv
// Top level: n-th term of a linear recurrence mod 104857601 by repeated halving.
// Loads complete without leaving the idle state. A query copies the stores, then
// runs one halving round per index halving, up to 63 rounds; each round is paced
// by the single MAC pipeline and the work memory.
// Reset (synchronous, active low) clears control and sets the order to one.
`default_nettype none
module linear_recurrence_nth_term import lrn_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [ORDER_W-1:0] i_cfg_wdata,
    lrn_req_if.sink                 i_req,
    lrn_rsp_if.source               o_rsp
);
    t_state r_state, n_state;
    logic [ORDER_W-1:0] r_order, n_order;
    logic [KW-1:0]      r_k, n_k;
    logic [IDXW-1:0]    r_idx, n_idx;
    logic               r_cinit, n_cinit;    // copy: stores to work (1) or compaction (0)
    logic               r_mext, n_mext;      // mac: term extension (1) or Q product (0)
    logic [OW-1:0]      r_c, n_c;
    logic               r_wv, n_wv;
    logic [AW-1:0]      r_wdst, n_wdst;
    logic [OW-1:0]      r_o, n_o;
    logic [OW-1:0]      r_j, n_j;
    logic [OW-1:0]      r_jend, n_jend;
    logic               r_iss, n_iss;
    logic               r_start, n_start;
    logic [DW-1:0]      r_acc, n_acc;
    t_mac_tag           r_t1, n_t1;
    logic               r_ovld, n_ovld;
    logic [DW-1:0]      r_odata, n_odata;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [AW-1:0] w_ra;
    logic [AW-1:0] w_rb;
    logic [DW-1:0] w_rda;
    logic [DW-1:0] w_rdb;
    t_mac_tag      w_tag;
    t_mac_res      w_res;
    logic [DW-1:0] w_mr;

    logic          w_fire;
    logic [DW-1:0] w_val;
    logic [KW-1:0] w_keff;
    logic [OW-1:0] w_k;
    logic [OW-1:0] w_clen;
    logic [OW-1:0] w_ck;
    logic [OW-1:0] w_e;
    logic [DW:0]   w_sum;
    logic [DW-1:0] w_acc_next;
    logic          w_mac_done;

    lrn_ram #(.W(DW), .D(RAM_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_ra),
        .i_raddr_b (w_rb),
        .o_rdata_a (w_rda),
        .o_rdata_b (w_rdb)
    );

    lrn_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_t1),
        .i_a     (w_rda),
        .i_b     (w_rdb),
        .o_res   (w_res),
        .o_r     (w_mr)
    );

    assign w_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_ovld;
    assign o_rsp.term  = r_odata;

    // Reduce a loaded value once: it is below 2M
    assign w_val = (i_req.value >= MODULUS) ? i_req.value - MODULUS : i_req.value;

    // Clamp the order register to 1..MAX_ORDER
    always_comb begin
        if (r_order == '0) begin
            w_keff = KW'(1);
        end else if (YW'(r_order) > YW'(MAX_ORDER)) begin
            w_keff = KW'(MAX_ORDER);
        end else begin
            w_keff = KW'(r_order);
        end
    end

    assign w_k    = OW'(r_k);
    assign w_clen = r_cinit ? (w_k << 1) : (w_k << 1) + OW'(1);
    assign w_ck   = r_c - w_k;
    assign w_e    = r_o << 1;

    // Accumulate one reduced product, adding or subtracting mod M
    assign w_sum = w_res.neg ? {1'b0, r_acc} + {1'b0, MODULUS} - {1'b0, w_mr}
                             : {1'b0, r_acc} + {1'b0, w_mr};
    assign w_acc_next = (w_sum >= {1'b0, MODULUS}) ? DW'(w_sum - {1'b0, MODULUS})
                                                   : DW'(w_sum);

    assign w_mac_done = !r_start && !r_iss && !r_t1.vld && !w_res.busy;

    always_comb begin
        n_state = r_state;
        n_order = r_order;
        n_k     = r_k;
        n_idx   = r_idx;
        n_cinit = r_cinit;
        n_mext  = r_mext;
        n_c     = r_c;
        n_wv    = 1'b0;
        n_wdst  = r_wdst;
        n_o     = r_o;
        n_j     = r_j;
        n_jend  = r_jend;
        n_iss   = r_iss;
        n_start = r_start;
        n_acc   = r_acc;
        n_ovld  = r_ovld;
        n_odata = r_odata;
        w_tag   = '0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_ra    = AW'(TERM_BASE) + AW'(r_idx[KW-1:0]);
        w_rb    = '0;

        if (i_cfg_we) begin
            n_order = i_cfg_wdata;
        end
        if (r_ovld && o_rsp.ready) begin
            n_ovld = 1'b0;
        end
        if (w_res.vld) begin
            n_acc = w_acc_next;
        end

        // Copy writes land in the cycle after their read
        if (r_wv) begin
            w_we    = 1'b1;
            w_waddr = r_wdst;
            w_wdata = w_rda;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    if (i_req.func == FN_LOAD_TERM) begin
                        if (XW'(i_req.slot) < XW'(w_keff)) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(INIT_BASE) + AW'(i_req.slot);
                            w_wdata = w_val;
                        end
                    end else if (i_req.func == FN_LOAD_COEF) begin
                        if (i_req.slot != '0 && XW'(i_req.slot) <= XW'(w_keff)) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(DEN_BASE) + AW'(i_req.slot);
                            w_wdata = neg_mod(w_val);
                        end
                    end else if (i_req.func == FN_QUERY) begin
                        // Leading coefficient of Q is always one
                        w_we    = 1'b1;
                        w_waddr = AW'(COEF_BASE);
                        w_wdata = DW'(1);
                        n_k     = w_keff;
                        n_idx   = i_req.term_number - IDXW'(1);
                        n_cinit = 1'b1;
                        n_c     = '0;
                        n_state = ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                if (r_c < w_clen) begin
                    n_wv = 1'b1;
                    n_c  = r_c + OW'(1);
                    if (r_cinit) begin
                        if (r_c < w_k) begin
                            w_ra   = AW'(INIT_BASE) + AW'(r_c);
                            n_wdst = AW'(TERM_BASE) + AW'(r_c);
                        end else begin
                            w_ra   = AW'(DEN_BASE) + AW'(w_ck) + AW'(1);
                            n_wdst = AW'(COEF_BASE) + AW'(w_ck) + AW'(1);
                        end
                    end else begin
                        if (r_c < w_k) begin
                            // keep the terms whose parity matches the index
                            w_ra   = AW'(TERM_BASE) + (AW'(r_c) << 1) + AW'(r_idx[0]);
                            n_wdst = AW'(TERM_BASE) + AW'(r_c);
                        end else begin
                            w_ra   = AW'(PROD_BASE) + AW'(w_ck);
                            n_wdst = AW'(COEF_BASE) + AW'(w_ck);
                        end
                    end
                end else if (!r_wv) begin
                    if (!r_cinit) begin
                        n_idx = r_idx >> 1;
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_idx < IDXW'(r_k)) begin
                    n_state = ST_OUT;
                end else begin
                    n_mext  = 1'b1;
                    n_o     = w_k;
                    n_start = 1'b1;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                w_ra = AW'(COEF_BASE) + AW'(r_j);
                w_rb = r_mext ? AW'(TERM_BASE) + AW'(r_o) - AW'(r_j)
                              : AW'(COEF_BASE) + AW'(w_e) - AW'(r_j);
                if (r_start) begin
                    // Open one inner sum
                    n_start = 1'b0;
                    n_iss   = 1'b1;
                    n_acc   = '0;
                    if (r_mext) begin
                        n_j    = OW'(1);
                        n_jend = w_k;
                    end else begin
                        n_j    = (w_e > w_k) ? w_e - w_k : '0;
                        n_jend = (w_e < w_k) ? w_e : w_k;
                    end
                end else if (r_iss) begin
                    w_tag.vld = 1'b1;
                    w_tag.neg = !r_mext && r_j[0];
                    if (r_j == r_jend) begin
                        n_iss = 1'b0;
                    end else begin
                        n_j = r_j + OW'(1);
                    end
                end else if (w_mac_done) begin
                    w_we    = 1'b1;
                    n_start = 1'b1;
                    if (r_mext) begin
                        w_waddr = AW'(TERM_BASE) + AW'(r_o);
                        w_wdata = neg_mod(r_acc);
                        if (r_o == (w_k << 1) - OW'(1)) begin
                            n_mext = 1'b0;
                            n_o    = '0;
                        end else begin
                            n_o = r_o + OW'(1);
                        end
                    end else begin
                        w_waddr = AW'(PROD_BASE) + AW'(r_o);
                        w_wdata = r_acc;
                        if (r_o == w_k) begin
                            n_start = 1'b0;
                            n_cinit = 1'b0;
                            n_c     = '0;
                            n_state = ST_COPY;
                        end else begin
                            n_o = r_o + OW'(1);
                        end
                    end
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld  = 1'b1;
                    n_odata = w_rda;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_t1 = w_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_order <= ORDER_W'(1);
            r_wv    <= 1'b0;
            r_iss   <= 1'b0;
            r_start <= 1'b0;
            r_t1    <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_order <= n_order;
            r_wv    <= n_wv;
            r_iss   <= n_iss;
            r_start <= n_start;
            r_t1    <= n_t1;
            r_ovld  <= n_ovld;
        end
        r_k     <= n_k;
        r_idx   <= n_idx;
        r_cinit <= n_cinit;
        r_mext  <= n_mext;
        r_c     <= n_c;
        r_wdst  <= n_wdst;
        r_o     <= n_o;
        r_j     <= n_j;
        r_jend  <= n_jend;
        r_acc   <= n_acc;
        r_odata <= n_odata;
    end
endmodule
`default_nettype wire

### src/lrn_chk.sv
// Port-level checker for the term engine, bound to the top level.
`default_nettype none
module lrn_chk import lrn_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic [FUNC_W-1:0] i_req_func,
    input wire logic              o_rsp_valid,
    input wire logic              o_rsp_ready,
    input wire logic [DW-1:0]     o_rsp_term
);
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp_valid)
        else $error("response valid right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid && $stable(o_rsp_term))
        else $error("stalled response changed");

    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp_term < MODULUS)
        else $error("term not reduced");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_func == FN_QUERY |=> !i_req_ready)
        else $error("ready after query request");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_func != FN_QUERY |=> i_req_ready)
        else $error("load request stalled the block");
endmodule

bind linear_recurrence_nth_term lrn_chk u_lrn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_func  (i_req.func),
    .o_rsp_valid (o_rsp.valid),
    .o_rsp_ready (o_rsp.ready),
    .o_rsp_term  (o_rsp.term)
);
`default_nettype wire
